[rtl/core/mips_subset_integer_execute_defines.svh]
// Assertion macros for the integer execute block.
`ifndef MIPS_SUBSET_INTEGER_EXECUTE_DEFINES_SVH
`define MIPS_SUBSET_INTEGER_EXECUTE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define MSE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: lbl failed");
// Next-cycle implication.
`define MSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: lbl failed");
`endif

[rtl/core/mse_pkg.sv]
// ----------------------------------------------------------------------------
// mse_pkg
// Types and constants shared by the integer execute block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mse_pkg;

  localparam int unsigned MemWordsDefault = 65536;
  localparam logic [31:0] JumpLimit = 32'h0100_0000;
  localparam logic [4:0]  LinkReg   = 5'd31;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [4:0] {
    ACT_NOP  = 5'd0,  ACT_ADD  = 5'd1,  ACT_SUB  = 5'd2,  ACT_MULT = 5'd3,
    ACT_DIV  = 5'd4,  ACT_SLT  = 5'd5,  ACT_AND  = 5'd6,  ACT_OR   = 5'd7,
    ACT_XOR  = 5'd8,  ACT_SLL  = 5'd9,  ACT_SRA  = 5'd10, ACT_SRL  = 5'd11,
    ACT_MOVE = 5'd12, ACT_ADDI = 5'd13, ACT_ANDI = 5'd14, ACT_ORI  = 5'd15,
    ACT_BEQ  = 5'd16, ACT_BNE  = 5'd17, ACT_LW   = 5'd18, ACT_SW   = 5'd19,
    ACT_J    = 5'd20, ACT_JAL  = 5'd21, ACT_JR   = 5'd22
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ERR  = 2'd1,
    ST_HALT = 2'd2
  } status_e;

  // operation class decided by the front end
  typedef enum logic [2:0] {
    CLS_ALU, CLS_MUL, CLS_DIV, CLS_BRANCH, CLS_MEM, CLS_JUMP, CLS_NONE
  } class_e;

  // back end sequencing
  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_EXEC, BK_MUL, BK_DIV, BK_LOAD, BK_OUT
  } back_state_e;

  typedef struct packed {
    logic [4:0]  action;
    logic [4:0]  src_reg;
    logic [4:0]  second_reg;
    logic [4:0]  dest_reg;
    logic [4:0]  shift_amount;
    logic signed [15:0] immediate;
    logic [24:0] jump_index;
  } instr_t;

  typedef struct packed {
    instr_t     ins;
    class_e     cls;
    logic       wr_en;      // writes a register when it succeeds
    logic [4:0] wr_idx;
  } op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  written_index;
    logic signed [31:0] written_value;
  } result_t;

endpackage

[rtl/core/mse_if.sv]
// ----------------------------------------------------------------------------
// mse_instr_if / mse_result_if
// Valid/ready channels carrying instructions and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mse_instr_if;
  logic valid;
  logic ready;
  logic [4:0] action;
  logic [4:0] src_reg;
  logic [4:0] second_reg;
  logic [4:0] dest_reg;
  logic [4:0] shift_amount;
  logic signed [15:0] immediate;
  logic [24:0] jump_index;
  modport source (output valid, action, src_reg, second_reg, dest_reg, shift_amount,
                  immediate, jump_index, input ready);
  modport sink (input valid, action, src_reg, second_reg, dest_reg, shift_amount,
                immediate, jump_index, output ready);
endinterface

interface mse_result_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [31:0] next_pc;
  logic reg_written;
  logic [4:0] written_index;
  logic signed [31:0] written_value;
  modport source (output valid, status, next_pc, reg_written, written_index,
                  written_value, input ready);
  modport sink (input valid, status, next_pc, reg_written, written_index,
                written_value, output ready);
endinterface

[rtl/core/mse_front.sv]
// ----------------------------------------------------------------------------
// mse_front
// Accepts instructions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mse_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mse_instr_if.sink     in_if,
  output logic          op_valid_o,
  input  logic          op_pop_i,
  output mse_pkg::op_t  op_o
);

  localparam int unsigned PtrW = $clog2(mse_pkg::QueueDepth);

  mse_pkg::op_t     queue_q [mse_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;
  mse_pkg::op_t     cls_op;
  logic             push;

  always_comb begin
    cls_op.ins.action       = in_if.action;
    cls_op.ins.src_reg      = in_if.src_reg;
    cls_op.ins.second_reg   = in_if.second_reg;
    cls_op.ins.dest_reg     = in_if.dest_reg;
    cls_op.ins.shift_amount = in_if.shift_amount;
    cls_op.ins.immediate    = in_if.immediate;
    cls_op.ins.jump_index   = in_if.jump_index;
    cls_op.cls    = mse_pkg::CLS_NONE;
    cls_op.wr_en  = 1'b0;
    cls_op.wr_idx = in_if.dest_reg;
    unique case (in_if.action) inside
      mse_pkg::ACT_ADD, mse_pkg::ACT_SUB, mse_pkg::ACT_SLT, mse_pkg::ACT_AND,
      mse_pkg::ACT_OR, mse_pkg::ACT_XOR, mse_pkg::ACT_SRA, mse_pkg::ACT_SRL: begin
        cls_op.cls = mse_pkg::CLS_ALU;
        cls_op.wr_en = 1'b1;
      end
      mse_pkg::ACT_SLL: begin
        cls_op.cls = mse_pkg::CLS_ALU;
        cls_op.wr_en = (in_if.src_reg != '0) || (in_if.second_reg != '0) ||
                       (in_if.dest_reg != '0) || (in_if.shift_amount != '0);
      end
      mse_pkg::ACT_MOVE, mse_pkg::ACT_ADDI, mse_pkg::ACT_ANDI, mse_pkg::ACT_ORI: begin
        cls_op.cls = mse_pkg::CLS_ALU;
        cls_op.wr_en = 1'b1;
        cls_op.wr_idx = in_if.second_reg;
      end
      mse_pkg::ACT_MULT: begin
        cls_op.cls = mse_pkg::CLS_MUL;
        cls_op.wr_en = 1'b1;
      end
      mse_pkg::ACT_DIV: begin
        cls_op.cls = mse_pkg::CLS_DIV;
        cls_op.wr_en = 1'b1;
      end
      mse_pkg::ACT_BEQ, mse_pkg::ACT_BNE: cls_op.cls = mse_pkg::CLS_BRANCH;
      mse_pkg::ACT_LW: begin
        cls_op.cls = mse_pkg::CLS_MEM;
        cls_op.wr_en = 1'b1;
        cls_op.wr_idx = in_if.second_reg;
      end
      mse_pkg::ACT_SW: cls_op.cls = mse_pkg::CLS_MEM;
      mse_pkg::ACT_J, mse_pkg::ACT_JR: cls_op.cls = mse_pkg::CLS_JUMP;
      mse_pkg::ACT_JAL: begin
        cls_op.cls = mse_pkg::CLS_JUMP;
        cls_op.wr_en = 1'b1;
        cls_op.wr_idx = mse_pkg::LinkReg;
      end
      default: cls_op.cls = mse_pkg::CLS_NONE;
    endcase
  end

  assign in_if.ready = (count_q != PtrW'(0) + (PtrW+1)'(mse_pkg::QueueDepth));
  assign push        = in_if.valid && in_if.ready;
  assign op_valid_o  = (count_q != '0);
  assign op_o        = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (op_pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (PtrW+1)'(push) - (PtrW+1)'(op_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= cls_op;
  end

endmodule

[rtl/core/mse_div.sv]
// ----------------------------------------------------------------------------
// mse_div
// Signed 32-bit divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mse_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic [31:0] rem_q, quo_q, den_q;
  logic [5:0]  cnt_q;
  logic        neg_q, busy_q, done_q;
  logic [32:0] trial;
  logic [31:0] shifted;

  assign shifted = {rem_q[30:0], quo_q[31]};
  assign trial   = {1'b0, shifted} - {1'b0, den_q};
  assign done_o  = done_q;
  assign quotient_o = neg_q ? (32'd0 - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      den_q <= divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      neg_q <= dividend_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

[rtl/core/mse_back.sv]
// ----------------------------------------------------------------------------
// mse_back
// Executes queued instructions against register file, data memory and pc.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mse_back #(
  parameter int unsigned MEM_WORDS = mse_pkg::MemWordsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  output logic          op_pop_o,
  input  mse_pkg::op_t  op_i,
  mse_result_if.source  out_if
);

  localparam int unsigned AddrW = $clog2(MEM_WORDS);

  mse_pkg::back_state_e state_q, state_d;

  logic [31:0] regs_q [32];
  logic [31:0] mem_q  [MEM_WORDS];
  logic [31:0] pc_q;
  mse_pkg::op_t op_q;
  logic [31:0] a_q, b_q, prod_q, mem_rd_q;
  mse_pkg::result_t res_q, res_d;
  logic        commit;
  logic        mem_we;

  logic        div_start, div_done;
  logic [31:0] div_quo;

  logic [31:0] imm_ext, pc_inc;
  logic signed [33:0] addr_full, br_full;

  mse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign imm_ext   = {{16{op_q.ins.immediate[15]}}, op_q.ins.immediate};
  assign pc_inc    = pc_q + 32'd1;
  assign addr_full = {{2{a_q[31]}}, a_q} + {{18{op_q.ins.immediate[15]}}, op_q.ins.immediate};
  assign br_full   = $signed({2'b00, pc_q}) + {{18{op_q.ins.immediate[15]}}, op_q.ins.immediate};

  assign out_if.valid         = (state_q == mse_pkg::BK_OUT);
  assign out_if.status        = res_q.status;
  assign out_if.next_pc       = res_q.next_pc;
  assign out_if.reg_written   = res_q.reg_written;
  assign out_if.written_index = res_q.written_index;
  assign out_if.written_value = res_q.written_value;

  function automatic mse_pkg::result_t ok_wr(mse_pkg::op_t o, logic [31:0] npc,
                                              logic [31:0] v);
    mse_pkg::result_t r;
    r.status        = mse_pkg::ST_OK;
    r.next_pc       = npc;
    r.reg_written   = o.wr_en;
    r.written_index = o.wr_en ? o.wr_idx : 5'd0;
    r.written_value = o.wr_en ? v : 32'd0;
    return r;
  endfunction

  function automatic mse_pkg::result_t fail(logic [1:0] st, logic [31:0] pc);
    mse_pkg::result_t r;
    r.status        = st;
    r.next_pc       = pc;
    r.reg_written   = 1'b0;
    r.written_index = '0;
    r.written_value = '0;
    return r;
  endfunction

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    op_pop_o  = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    commit    = 1'b0;
    unique case (state_q)
      mse_pkg::BK_IDLE: if (op_valid_i) begin
        op_pop_o = 1'b1;
        state_d  = mse_pkg::BK_READ;
      end
      mse_pkg::BK_READ: state_d = mse_pkg::BK_EXEC;
      mse_pkg::BK_EXEC: begin
        state_d = mse_pkg::BK_OUT;
        commit  = 1'b1;
        case (op_q.cls)
          mse_pkg::CLS_ALU: begin
            case (op_q.ins.action)
              mse_pkg::ACT_ADD:  res_d = ok_wr(op_q, pc_inc, a_q + b_q);
              mse_pkg::ACT_SUB:  res_d = ok_wr(op_q, pc_inc, a_q - b_q);
              mse_pkg::ACT_SLT:  res_d = ok_wr(op_q, pc_inc,
                                   {31'd0, $signed(a_q) < $signed(b_q)});
              mse_pkg::ACT_AND:  res_d = ok_wr(op_q, pc_inc, a_q & b_q);
              mse_pkg::ACT_OR:   res_d = ok_wr(op_q, pc_inc, a_q | b_q);
              mse_pkg::ACT_XOR:  res_d = ok_wr(op_q, pc_inc, a_q ^ b_q);
              mse_pkg::ACT_SLL:  res_d = ok_wr(op_q, pc_inc, b_q << op_q.ins.shift_amount);
              mse_pkg::ACT_SRA:  res_d = ok_wr(op_q, pc_inc,
                                   32'($signed(b_q) >>> op_q.ins.shift_amount));
              mse_pkg::ACT_SRL:  res_d = ok_wr(op_q, pc_inc, b_q >> op_q.ins.shift_amount);
              mse_pkg::ACT_MOVE: res_d = ok_wr(op_q, pc_inc, a_q);
              mse_pkg::ACT_ADDI: res_d = ok_wr(op_q, pc_inc, a_q + imm_ext);
              mse_pkg::ACT_ANDI: res_d = ok_wr(op_q, pc_inc, a_q & imm_ext);
              default:           res_d = ok_wr(op_q, pc_inc, a_q | imm_ext);
            endcase
          end
          mse_pkg::CLS_MUL: begin
            commit  = 1'b0;
            state_d = mse_pkg::BK_MUL;
          end
          mse_pkg::CLS_DIV: begin
            if (b_q == '0) res_d = fail(mse_pkg::ST_ERR, pc_q);
            else begin
              commit    = 1'b0;
              div_start = 1'b1;
              state_d   = mse_pkg::BK_DIV;
            end
          end
          mse_pkg::CLS_BRANCH: begin
            if ((op_q.ins.action == mse_pkg::ACT_BEQ) == (a_q == b_q)) begin
              if (br_full < 0) res_d = fail(mse_pkg::ST_ERR, pc_q);
              else res_d = ok_wr(op_q, br_full[31:0], '0);
            end else res_d = ok_wr(op_q, pc_inc, '0);
          end
          mse_pkg::CLS_MEM: begin
            if (addr_full < 0 || addr_full >= 34'(MEM_WORDS)) begin
              res_d = fail(mse_pkg::ST_ERR, pc_q);
            end else if (op_q.ins.action == mse_pkg::ACT_LW) begin
              commit  = 1'b0;
              state_d = mse_pkg::BK_LOAD;
            end else begin
              mem_we = 1'b1;
              res_d  = ok_wr(op_q, pc_inc, '0);
            end
          end
          mse_pkg::CLS_JUMP: begin
            if (op_q.ins.action == mse_pkg::ACT_JR) begin
              if (b_q[31]) res_d = fail(mse_pkg::ST_ERR, pc_q);
              else res_d = ok_wr(op_q, b_q, '0);
            end else if ({7'd0, op_q.ins.jump_index} > mse_pkg::JumpLimit) begin
              res_d = fail(mse_pkg::ST_ERR, pc_q);
            end else if (op_q.ins.action == mse_pkg::ACT_J &&
                         {7'd0, op_q.ins.jump_index} == pc_q) begin
              res_d = fail(mse_pkg::ST_HALT, pc_q);
            end else begin
              res_d = ok_wr(op_q, {7'd0, op_q.ins.jump_index}, pc_inc);
            end
          end
          default: res_d = ok_wr(op_q, pc_inc, '0);
        endcase
      end
      mse_pkg::BK_MUL: begin
        res_d   = ok_wr(op_q, pc_inc, prod_q);
        commit  = 1'b1;
        state_d = mse_pkg::BK_OUT;
      end
      mse_pkg::BK_DIV: if (div_done) begin
        res_d   = ok_wr(op_q, pc_inc, div_quo);
        commit  = 1'b1;
        state_d = mse_pkg::BK_OUT;
      end
      mse_pkg::BK_LOAD: begin
        res_d   = ok_wr(op_q, pc_inc, mem_rd_q);
        commit  = 1'b1;
        state_d = mse_pkg::BK_OUT;
      end
      mse_pkg::BK_OUT: if (out_if.ready) state_d = mse_pkg::BK_IDLE;
      default: state_d = mse_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mse_pkg::BK_IDLE;
      pc_q    <= '0;
      for (int i = 0; i < 32; i++) regs_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        pc_q <= res_d.next_pc;
        if (res_d.reg_written) regs_q[res_d.written_index] <= res_d.written_value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (op_pop_o) op_q <= op_i;
    if (state_q == mse_pkg::BK_READ) begin
      a_q <= regs_q[op_q.ins.src_reg];
      b_q <= regs_q[op_q.ins.second_reg];
    end
    prod_q <= 32'(a_q * b_q);
  end

  // read at the execute edge, used in the load state
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[addr_full[AddrW-1:0]] <= b_q;
    mem_rd_q <= mem_q[addr_full[AddrW-1:0]];
  end

endmodule

[rtl/core/mips_subset_integer_execute.sv]
// ----------------------------------------------------------------------------
// mips_subset_integer_execute
// Integer execute of a MIPS-like subset, with front queue and back executor.
// ----------------------------------------------------------------------------
//  channel   dir  role
//  instr_if  in   decoded instruction
//  result_if out  status, next pc, register write
//
//  Steps per instruction: queue pop, register read, execute, result; mult
//  and lw add a multiply or load state, div waits on the bit-serial divider.
//  Reset clears pc and the register file at once; data memory is not cleared.
//  The front queue (2 entries) keeps accepting while a result is stalled, until it is full.
`timescale 1ns / 1ps
module mips_subset_integer_execute #(
  parameter int unsigned MEM_WORDS = mse_pkg::MemWordsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mse_instr_if.sink    instr_if,
  mse_result_if.source result_if
);

  logic         op_valid, op_pop;
  mse_pkg::op_t op;

  mse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (instr_if),
    .op_valid_o (op_valid),
    .op_pop_i   (op_pop),
    .op_o       (op)
  );

  mse_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_pop_o   (op_pop),
    .op_i       (op),
    .out_if     (result_if)
  );

endmodule

[rtl/core/mse_checker.sv]
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks on the integer execute block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mips_subset_integer_execute_defines.svh"
module mse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic        reg_written_i,
  input logic [4:0]  written_index_i,
  input logic [31:0] written_value_i
);
  `MSE_ASSERT_IMPL(a_status_legal, clk_i, rst_ni, out_valid_i, status_i <= mse_pkg::ST_HALT)
  `MSE_ASSERT_IMPL(a_fail_no_write, clk_i, rst_ni, out_valid_i && status_i != mse_pkg::ST_OK, !reg_written_i)
  `MSE_ASSERT_IMPL(a_idle_zero, clk_i, rst_ni, out_valid_i && !reg_written_i, written_index_i == 5'd0 && written_value_i == 32'd0)
  `MSE_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(written_value_i))
endmodule

bind mips_subset_integer_execute mse_checker u_mse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (result_if.valid),
  .out_ready_i     (result_if.ready),
  .status_i        (result_if.status),
  .reg_written_i   (result_if.reg_written),
  .written_index_i (result_if.written_index),
  .written_value_i (result_if.written_value)
);
